// File: rtl/stok_pkg.sv
// ----------------------------------------------------------------------------
// Script tokenizer package
// Shared types, character codes and register map of the script tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_HIGH_BYTES = 1'b0;

   // Result queue between front and back
   localparam int QUEUE_DEPTH_DEF = 4;

   // Token kinds
   localparam logic [1:0] KIND_WORD  = 2'd0;
   localparam logic [1:0] KIND_QUOTE = 2'd1;
   localparam logic [1:0] KIND_DELIM = 2'd2;

   // Character codes
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_COMMA   = 8'h2c;
   localparam logic [7:0] CH_SLASH   = 8'h2f;
   localparam logic [7:0] CH_LBRACE  = 8'h7b;
   localparam logic [7:0] CH_RBRACE  = 8'h7d;

   typedef enum logic [2:0] {
      MODE_SKIP    = 3'd0,
      MODE_SLASH   = 3'd1,
      MODE_COMMENT = 3'd2,
      MODE_QUOTE   = 3'd3,
      MODE_WORD    = 3'd4
   } stok_mode_type;

   typedef struct packed {
      logic       has_char;
      logic [7:0] token_char;
      logic       token_last;
      logic [1:0] token_kind;
      logic       input_done;
   } stok_res_type;

   // One queue entry holds the results of one input byte (one or two).
   typedef struct packed {
      logic         two;
      stok_res_type r0;
      stok_res_type r1;
   } stok_entry_type;

   typedef struct packed {
      logic           not_empty;
      stok_entry_type head;
   } stok_qstat_type;

endpackage

// File: rtl/stok_req_if.sv
// ----------------------------------------------------------------------------
// Script tokenizer input channel
// Valid/ready channel carrying one text byte per item.
// ----------------------------------------------------------------------------
interface stok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

// File: rtl/stok_rsp_if.sv
// ----------------------------------------------------------------------------
// Script tokenizer result channel
// Valid/ready channel carrying one token byte or marker per item.
// ----------------------------------------------------------------------------
interface stok_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_char;
   logic [7:0] token_char;
   logic       token_last;
   logic [1:0] token_kind;
   logic       input_done;

   modport source (output valid, output has_char, output token_char,
                   output token_last, output token_kind, output input_done,
                   input ready);
   modport sink (input valid, input has_char, input token_char,
                 input token_last, input token_kind, input input_done,
                 output ready);
endinterface

// File: rtl/stok_front.sv
// ----------------------------------------------------------------------------
// Script tokenizer front end
// Accepts text bytes, runs the lexer state machine and queues the results
// that each byte produces.
// ----------------------------------------------------------------------------
module stok_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    high_bytes_as_space,
   stok_req_if.sink                req_chan,
   input  logic                    queue_full,
   output logic                    push,
   output stok_pkg::stok_entry_type push_entry
);
   import stok_pkg::*;

   stok_mode_type mode_ff, mode_in;
   logic          accept;
   logic [7:0]    c;
   logic          n_valid0, n_valid1;
   stok_res_type  r0, r1;
   logic          start_valid;
   stok_res_type  start_res;

   function automatic logic is_space(input logic [7:0] ch, input logic hbs);
      return (ch <= CH_SPACE) || (ch[7] && hbs);
   endfunction

   function automatic logic is_delim(input logic [7:0] ch);
      return (ch == CH_LBRACE) || (ch == CH_RBRACE) || (ch == CH_LPAREN) ||
             (ch == CH_RPAREN) || (ch == CH_SQUOTE) || (ch == CH_COMMA);
   endfunction

   function automatic stok_res_type mk_res(input logic has, input logic [7:0] ch,
                                           input logic last, input logic [1:0] kind,
                                           input logic done);
      stok_res_type r;
      r.has_char   = has;
      r.token_char = ch;
      r.token_last = last;
      r.token_kind = kind;
      r.input_done = done;
      return r;
   endfunction

   function automatic stok_mode_type start_mode(input logic [7:0] ch, input logic hbs);
      stok_mode_type m;
      priority if (is_space(ch, hbs)) m = MODE_SKIP;
      else if (ch == CH_SLASH)        m = MODE_SLASH;
      else if (ch == CH_DQUOTE)       m = MODE_QUOTE;
      else if (is_delim(ch))          m = MODE_SKIP;
      else                            m = MODE_WORD;
      return m;
   endfunction

   assign c        = req_chan.char_in;
   assign accept   = req_chan.valid && !queue_full;
   assign req_chan.ready = !queue_full;

   // A byte that terminates a word or a pending slash.
   logic ends_word;
   assign ends_word = is_space(c, high_bytes_as_space) || is_delim(c);

   // Result of a byte seen while no token is open.
   always_comb begin
      start_valid = 1'b0;
      start_res   = mk_res(1'b0, CH_NUL, 1'b0, KIND_WORD, 1'b1);
      priority if (c == CH_NUL) begin
         start_valid = 1'b1;
      end else if (is_space(c, high_bytes_as_space) || c == CH_SLASH ||
                   c == CH_DQUOTE) begin
         start_valid = 1'b0;
      end else if (is_delim(c)) begin
         start_valid = 1'b1;
         start_res   = mk_res(1'b1, c, 1'b1, KIND_DELIM, 1'b0);
      end else begin
         start_valid = 1'b1;
         start_res   = mk_res(1'b1, c, 1'b0, KIND_WORD, 1'b0);
      end
   end

   // Next state
   always_comb begin
      mode_in = mode_ff;
      unique case (mode_ff)
         MODE_SLASH: begin
            priority if (c == CH_SLASH) mode_in = MODE_COMMENT;
            else if (ends_word)         mode_in = start_mode(c, high_bytes_as_space);
            else                        mode_in = MODE_WORD;
         end
         MODE_COMMENT: begin
            if (c == CH_NUL || c == CH_NEWLINE) mode_in = MODE_SKIP;
         end
         MODE_QUOTE: begin
            if (c == CH_NUL || c == CH_DQUOTE) mode_in = MODE_SKIP;
         end
         MODE_WORD: begin
            if (ends_word) mode_in = start_mode(c, high_bytes_as_space);
         end
         default: mode_in = start_mode(c, high_bytes_as_space);
      endcase
   end

   // Results of the byte; the first slot is always filled before the second.
   always_comb begin
      n_valid0 = 1'b0;
      n_valid1 = 1'b0;
      r0       = mk_res(1'b0, CH_NUL, 1'b0, KIND_WORD, 1'b0);
      r1       = mk_res(1'b0, CH_NUL, 1'b0, KIND_WORD, 1'b0);
      unique case (mode_ff)
         MODE_SLASH: begin
            priority if (c == CH_SLASH) begin
               n_valid0 = 1'b0;
            end else if (ends_word) begin
               n_valid0 = 1'b1;
               r0       = mk_res(1'b1, CH_SLASH, 1'b1, KIND_WORD, 1'b0);
               n_valid1 = start_valid;
               r1       = start_res;
            end else begin
               n_valid0 = 1'b1;
               r0       = mk_res(1'b1, CH_SLASH, 1'b0, KIND_WORD, 1'b0);
               n_valid1 = 1'b1;
               r1       = mk_res(1'b1, c, 1'b0, KIND_WORD, 1'b0);
            end
         end
         MODE_COMMENT: begin
            n_valid0 = (c == CH_NUL);
            r0       = mk_res(1'b0, CH_NUL, 1'b0, KIND_WORD, 1'b1);
         end
         MODE_QUOTE: begin
            n_valid0 = 1'b1;
            priority if (c == CH_NUL) begin
               r0       = mk_res(1'b0, CH_NUL, 1'b1, KIND_QUOTE, 1'b0);
               n_valid1 = 1'b1;
               r1       = mk_res(1'b0, CH_NUL, 1'b0, KIND_WORD, 1'b1);
            end else if (c == CH_DQUOTE) begin
               r0 = mk_res(1'b0, CH_NUL, 1'b1, KIND_QUOTE, 1'b0);
            end else begin
               r0 = mk_res(1'b1, c, 1'b0, KIND_QUOTE, 1'b0);
            end
         end
         MODE_WORD: begin
            n_valid0 = 1'b1;
            if (ends_word) begin
               r0       = mk_res(1'b0, CH_NUL, 1'b1, KIND_WORD, 1'b0);
               n_valid1 = start_valid;
               r1       = start_res;
            end else begin
               r0 = mk_res(1'b1, c, 1'b0, KIND_WORD, 1'b0);
            end
         end
         default: begin
            n_valid0 = start_valid;
            r0       = start_res;
         end
      endcase
   end

   assign push          = accept && n_valid0;
   assign push_entry.two = n_valid1;
   assign push_entry.r0  = r0;
   assign push_entry.r1  = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SKIP;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule

// File: rtl/stok_queue.sv
// ----------------------------------------------------------------------------
// Script tokenizer result queue
// Small register FIFO of per-byte result groups between front and back end.
// ----------------------------------------------------------------------------
module stok_queue #(
   parameter int DEPTH = stok_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  stok_pkg::stok_entry_type push_entry,
   input  logic                     pop,
   output logic                     full,
   output stok_pkg::stok_qstat_type qstat
);
   import stok_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   stok_entry_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full            = (count_ff == FULL_CNT);
   assign qstat.not_empty = (count_ff != '0);
   assign qstat.head      = mem_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && qstat.not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// File: rtl/stok_back.sv
// ----------------------------------------------------------------------------
// Script tokenizer back end
// Unpacks queued result groups and drives them out one item per cycle,
// while rsp_chan is ready, through an output register.
// ----------------------------------------------------------------------------
module stok_back (
   input  logic                     clock,
   input  logic                     reset,
   input  stok_pkg::stok_qstat_type qstat,
   output logic                     pop,
   stok_rsp_if.source               rsp_chan
);
   import stok_pkg::*;

   logic         out_valid_ff, out_valid_in;
   stok_res_type out_res_ff, out_res_in;
   logic         pend_valid_ff, pend_valid_in;
   stok_res_type pend_res_ff, pend_res_in;
   logic         load;

   assign load = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_res_in    = out_res_ff;
      pend_valid_in = pend_valid_ff;
      pend_res_in   = pend_res_ff;
      pop           = 1'b0;
      if (load) begin
         // The second result of a group goes out before the next group.
         priority if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_res_in    = pend_res_ff;
            pend_valid_in = 1'b0;
         end else if (qstat.not_empty) begin
            pop           = 1'b1;
            out_valid_in  = 1'b1;
            out_res_in    = qstat.head.r0;
            pend_valid_in = qstat.head.two;
            pend_res_in   = qstat.head.r1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      pend_res_ff <= pend_res_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.has_char   = out_res_ff.has_char;
   assign rsp_chan.token_char = out_res_ff.token_char;
   assign rsp_chan.token_last = out_res_ff.token_last;
   assign rsp_chan.token_kind = out_res_ff.token_kind;
   assign rsp_chan.input_done = out_res_ff.input_done;

endmodule

// File: rtl/script_tokenizer_top.sv
// ----------------------------------------------------------------------------
// Script tokenizer
// Streaming tokenizer for script text: one byte in, token bytes out.
// ----------------------------------------------------------------------------
// The tokenizer takes one text byte per cycle on req_chan while the queue
// has room and emits token bytes and end-of-token markers on rsp_chan, one
// item per cycle while rsp_chan is ready. The front end classifies each byte
// in the cycle it is accepted and writes the one or two results it causes
// into a result queue of QUEUE_DEPTH entries; bytes with no result
// (whitespace outside a token, comment text, opening quotes, a held slash)
// take no queue space. The back end drains the queue through an output
// register, so the output port sets the pace: each result is one output
// item, so a word or held slash ended by a delimiter or end of input, a held
// slash followed by a word byte, or end of input inside a quote yields two.
// The register high_bytes_as_space lives at address 0 and resets to 1.
// ----------------------------------------------------------------------------
module script_tokenizer_top #(
   parameter int QUEUE_DEPTH = stok_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   stok_req_if.sink                        req_chan,
   stok_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [stok_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [stok_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [stok_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import stok_pkg::*;

   logic           high_bytes_ff, high_bytes_in;
   logic           csr_hit;
   logic           queue_full;
   logic           push;
   stok_entry_type push_entry;
   logic           pop;
   stok_qstat_type qstat;

   // Register index is paddr[2]; only index 0 exists.
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == CSR_IDX_HIGH_BYTES);

   always_comb begin
      high_bytes_in = high_bytes_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         high_bytes_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_bytes_ff <= 1'b1;
      end else begin
         high_bytes_ff <= high_bytes_in;
      end
   end

   assign csr_prdata = csr_hit ? {{(CSR_DATA_W-1){1'b0}}, high_bytes_ff} : '0;

   stok_front u_front (
      .clock               (clock),
      .reset               (reset),
      .high_bytes_as_space (high_bytes_ff),
      .req_chan            (req_chan),
      .queue_full          (queue_full),
      .push                (push),
      .push_entry          (push_entry)
   );

   stok_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .qstat      (qstat)
   );

   stok_back u_back (
      .clock    (clock),
      .reset    (reset),
      .qstat    (qstat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
